// ===== design/line_point_stepper_assert.svh =====
// assertion macros for the line point stepper
// used by design/line_point_stepper.sv, no other dependencies
`ifndef LINE_POINT_STEPPER_ASSERT_SVH
`define LINE_POINT_STEPPER_ASSERT_SVH

`ifndef ASSERT_OFF
// general clocked property, disabled while reset is asserted
`define LPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same-cycle implication, disabled while reset is asserted
`define LPS_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define LPS_ASSERT(label, clk, rst_n, prop, msg)
`define LPS_ASSERT_IMPL(label, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== design/lps_pkg.sv =====
// shared types and constants for the line point stepper
// no dependencies
`timescale 1ns / 1ps

package lps_pkg;

  localparam int unsigned COORD_BITS_DEF = 8;   // default internal coordinate width
  localparam int unsigned FIELD_W        = 8;   // coordinate field width on the ports
  localparam int unsigned COLOR_W        = 16;
  localparam int unsigned ERR_W          = 11;
  localparam int unsigned S_TDATA_W      = 48;
  localparam int unsigned M_TDATA_W      = 32;

  typedef enum logic [1:0] {
    MODE_STEEP_RIGHT   = 2'd0,
    MODE_SHALLOW_RIGHT = 2'd1,
    MODE_STEEP_LEFT    = 2'd2,
    MODE_SHALLOW_LEFT  = 2'd3
  } mode_e;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_e;

  // input payload, first member at the top
  typedef struct packed {
    logic [COLOR_W-1:0] pen_color;
    logic [FIELD_W-1:0] y_end;
    logic [FIELD_W-1:0] x_end;
    logic [FIELD_W-1:0] y_start;
    logic [FIELD_W-1:0] x_start;
  } start_t;

  // result payload
  typedef struct packed {
    logic [COLOR_W-1:0] point_color;
    logic [FIELD_W-1:0] point_y;
    logic [FIELD_W-1:0] point_x;
  } point_t;

endpackage

// ===== design/line_point_stepper.sv =====
// line point stepper: error-term line rasterizer, at most one point per transfer
// depends on lps_pkg.sv and line_point_stepper_assert.svh
`timescale 1ns / 1ps
// datapath: an input transfer goes into the input register, then its result into the
//   result register, from which it leaves; a stalled output holds both stages
// throughput: one item per cycle unless output stalls; one line state pass per item
// reset: rst_ni is asynchronous and active low; it clears the line state, leaves the
//   block idle with no line in progress and both register stages empty
`include "line_point_stepper_assert.svh"

module line_point_stepper #(
  parameter int unsigned COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave side
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], pen_color[47:32]
  input  logic [lps_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // func[0]: 0 start a line, 1 step to the next point
  input  logic [0:0]                   s_axis_tuser,
  // master side
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // point_x[7:0], point_y[15:8], point_color[31:16]
  output logic [lps_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // last_point
  output logic                         m_axis_tlast
);

  import lps_pkg::*;

  localparam int unsigned CW = COORD_BITS;

  // true when the line in its current state has no more points to give
  function automatic logic done_f(input mode_e m, input logic [CW-1:0] cx,
                                  input logic [CW-1:0] cy, input logic [CW-1:0] gx,
                                  input logic [CW-1:0] gy);
    logic d;
    case (m) inside
      MODE_STEEP_RIGHT, MODE_STEEP_LEFT: d = !(cy < gy);
      MODE_SHALLOW_RIGHT:                d = !(cx < gx);
      default:                           d = !(cx > gx);
    endcase
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // input register stage
  // ---------------------------------------------------------------------------
  logic           a_valid_q;
  func_e          a_func_q;
  start_t         a_item_q;
  logic           a_adv;     // item leaves the input register this cycle

  // the input register empties whenever the result register can take a value
  assign a_adv         = a_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !a_valid_q || a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      a_func_q <= func_e'(s_axis_tuser[0]);
      a_item_q <= start_t'(s_axis_tdata);
    end
  end

  // ---------------------------------------------------------------------------
  // line state
  // ---------------------------------------------------------------------------
  logic        [CW-1:0]      cur_x_q, cur_x_d;
  logic        [CW-1:0]      cur_y_q, cur_y_d;
  logic        [CW-1:0]      goal_x_q, goal_x_d;
  logic        [CW-1:0]      goal_y_q, goal_y_d;
  logic        [FIELD_W-1:0] span_x_q, span_x_d;
  logic        [FIELD_W-1:0] span_y_q, span_y_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  mode_e                     mode_q, mode_d;
  logic                      busy_q, busy_d;
  logic        [COLOR_W-1:0] color_q, color_d;

  // start decode: order endpoints so y ascends, then classify the line
  logic               swap;
  logic [FIELD_W-1:0] p1x, p1y, p2x, p2y;
  logic [FIELD_W:0]   dx_s;     // signed x span, one extra bit for the sign
  logic               left;
  logic [FIELD_W-1:0] adx, dy;
  logic               steep;
  mode_e              start_mode;
  logic [CW-1:0]      start_x, start_y, start_y_row;

  assign swap  = a_item_q.y_start > a_item_q.y_end;
  assign p1x   = swap ? a_item_q.x_end   : a_item_q.x_start;
  assign p1y   = swap ? a_item_q.y_end   : a_item_q.y_start;
  assign p2x   = swap ? a_item_q.x_start : a_item_q.x_end;
  assign p2y   = swap ? a_item_q.y_start : a_item_q.y_end;
  assign dx_s  = {1'b0, p2x} - {1'b0, p1x};
  assign left  = dx_s[FIELD_W];
  assign adx   = left ? FIELD_W'(-dx_s) : dx_s[FIELD_W-1:0];
  assign dy    = p2y - p1y;
  assign steep = dy > adx;
  assign start_mode  = mode_e'({left, !steep});
  assign start_x     = CW'(p1x);
  assign start_y_row = CW'(p1y);
  // horizontal line: y sits one row low so the first diagonal step restores it
  assign start_y     = (!steep && (dy == '0)) ? start_y_row - CW'(1) : start_y_row;

  // step decode from the held line state
  logic                    step_steep, step_left, err_neg;
  logic        [CW-1:0]    xmove, yup;
  logic signed [ERR_W-1:0] sx_e, sy_e;

  assign step_steep = !mode_q[0];
  assign step_left  = mode_q[1];
  assign err_neg    = err_q[ERR_W-1];
  assign xmove      = step_left ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
  assign yup        = cur_y_q + CW'(1);
  assign sx_e       = ERR_W'(span_x_q);
  assign sy_e       = ERR_W'(span_y_q);

  // result register inputs
  logic   load_out;
  point_t res_d;
  logic   res_last;

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    span_x_d = span_x_q;
    span_y_d = span_y_q;
    err_d    = err_q;
    mode_d   = mode_q;
    busy_d   = busy_q;
    color_d  = color_q;
    load_out = 1'b0;
    res_d    = '0;
    res_last = 1'b0;

    if (a_adv) begin
      if (a_func_q == FUNC_START) begin
        // a start always wins, any line in progress is dropped
        cur_x_d  = start_x;
        cur_y_d  = start_y;
        goal_x_d = CW'(p2x);
        goal_y_d = CW'(p2y);
        span_x_d = adx;
        span_y_d = dy;
        err_d    = '0;
        mode_d   = start_mode;
        color_d  = a_item_q.pen_color;
        busy_d   = !done_f(start_mode, start_x, start_y, CW'(p2x), CW'(p2y));
        load_out = 1'b1;
        res_d.point_x     = p1x;
        res_d.point_y     = p1y;
        res_d.point_color = a_item_q.pen_color;
        res_last          = !busy_d;
      end else if (busy_q) begin
        if (step_steep) begin
          if (err_neg) begin
            cur_x_d = xmove;
            err_d   = err_q + sy_e - sx_e;
          end else begin
            err_d   = err_q - sx_e;
          end
          cur_y_d = yup;
        end else begin
          if (err_neg) begin
            err_d   = err_q + sy_e;
          end else begin
            cur_y_d = yup;
            err_d   = err_q + sy_e - sx_e;
          end
          cur_x_d = xmove;
        end
        busy_d   = !done_f(mode_q, cur_x_d, cur_y_d, goal_x_q, goal_y_q);
        load_out = 1'b1;
        res_d.point_x     = cur_x_d[FIELD_W-1:0];
        res_d.point_y     = cur_y_d[FIELD_W-1:0];
        res_d.point_color = color_q;
        res_last          = !busy_d;
      end
      // a step with no line in progress is consumed silently
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      span_x_q <= '0;
      span_y_q <= '0;
      err_q    <= '0;
      mode_q   <= MODE_STEEP_RIGHT;
      busy_q   <= 1'b0;
      color_q  <= '0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      goal_x_q <= goal_x_d;
      goal_y_q <= goal_y_d;
      span_x_q <= span_x_d;
      span_y_q <= span_y_d;
      err_q    <= err_d;
      mode_q   <= mode_d;
      busy_q   <= busy_d;
      color_q  <= color_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic   out_valid_q;
  point_t out_q;
  logic   out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q      <= res_d;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_q);
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  logic line_done_now;
  assign line_done_now = done_f(mode_q, cur_x_q, cur_y_q, goal_x_q, goal_y_q);

  `LPS_ASSERT_IMPL(a_busy_not_done, clk_i, rst_ni, busy_q, !line_done_now, "busy with line already finished")
  `LPS_ASSERT(a_last_goes_idle, clk_i, rst_ni, load_out && res_last |=> !busy_q, "last point left line busy")
  `LPS_ASSERT(a_more_stays_busy, clk_i, rst_ni, load_out && !res_last |=> busy_q, "line went idle before last point")
  `LPS_ASSERT_IMPL(a_idle_step_silent, clk_i, rst_ni, a_adv && (a_func_q == FUNC_STEP) && !busy_q, !load_out, "step while idle made a point")
  `LPS_ASSERT_IMPL(a_err_range, clk_i, rst_ni, busy_q, (err_q >= -256) && (err_q <= 255), "error term out of range")

endmodule
